[hw/rtl/maximal_square_area_defines.svh]
// Assertion macros shared by the maximal square area RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MAXIMAL_SQUARE_AREA_DEFINES_SVH
`define MAXIMAL_SQUARE_AREA_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/msa_pkg.sv]
// Package for the maximal square area block: widths, reset values, shared types.
// Depends on nothing; imported by every module of the block.
package msa_pkg;

    localparam int SIDE_W      = 11;
    localparam int AREA_W      = 21;
    localparam int ROW_WIDTH_W = 11;
    localparam int MAX_COLS_DEF = 1024;
    localparam int RES_DEPTH   = 4;

    typedef logic [SIDE_W-1:0]      t_side;
    typedef logic [AREA_W-1:0]      t_area;
    typedef logic [ROW_WIDTH_W-1:0] t_row_width;

    localparam t_row_width ROW_WIDTH_RST = t_row_width'(1024);
    localparam t_side      SIDE_ZERO     = '0;
    localparam t_side      SIDE_MAX      = '1;

    // Result side handed from the cell pipeline to the result stage.
    typedef struct packed {
        logic  valid;
        t_side side;
    } t_res_push;

endpackage

[hw/rtl/msa_if.sv]
// Valid/ready channel interfaces for the cell stream and the result stream.
// Depends on msa_pkg for the payload types.
interface msa_in_if;
    logic valid;
    logic ready;
    logic cell_bit;
    logic matrix_end;

    modport source (output valid, output cell_bit, output matrix_end, input ready);
    modport sink   (input valid, input cell_bit, input matrix_end, output ready);
endinterface

interface msa_out_if
    import msa_pkg::*;
;
    logic  valid;
    logic  ready;
    t_area square_area;
    t_side square_side;

    modport source (output valid, output square_area, output square_side, input ready);
    modport sink   (input valid, input square_area, input square_side, output ready);
endinterface

[hw/rtl/msa_lbuf.sv]
// Line buffer holding the square sides of the previous row.
// Depends on msa_pkg; one write port, one read port with registered read data.
module msa_lbuf
    import msa_pkg::*;
#(
    parameter int DEPTH  = MAX_COLS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_side             o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_side             i_wr_data
);

    t_side mem [DEPTH];
    t_side r_rd_data;

    // Synchronous read; a same-address write in this cycle is not seen.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/msa_cell.sv]
// Cell pipeline: column tracking, line buffer access and the side computation.
// Depends on msa_pkg; drives msa_lbuf and feeds msa_result.
module msa_cell
    import msa_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int ADDR_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_row_width        i_cfg_wdata,
    input  logic              i_acc,
    input  logic              i_cell_bit,
    input  logic              i_matrix_end,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  t_side             i_rd_data,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output t_side             o_wr_data,
    output t_res_push         o_push
);

    localparam int NW   = $clog2(MAX_COLS + 1);
    localparam int CMPW = (NW > ROW_WIDTH_W) ? NW : ROW_WIDTH_W;
    localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_COLS);
    localparam logic [CMPW-1:0] ONE_CMP = CMPW'(1);

    t_row_width        r_row_width;
    logic [ADDR_W-1:0] r_col;
    logic              r_first;

    logic              r_s1_vld;
    logic              r_s1_cell;
    logic              r_s1_last;
    logic [ADDR_W-1:0] r_s1_col;
    logic              r_s1_col0;
    logic              r_s1_first;
    logic              r_fwd;
    t_side             r_fwd_data;

    t_side             r_left;
    t_side             r_diag;
    t_side             r_best;

    logic [CMPW-1:0]   width_ext;
    logic [CMPW-1:0]   eff_width;
    logic [CMPW-1:0]   col_next;
    logic              row_wrap;
    t_side             prev_side;
    t_side             up;
    t_side             left;
    t_side             diag;
    t_side             min_lu;
    t_side             min3;
    logic [SIDE_W:0]   sum;
    t_side             side;
    t_side             best_new;

    // Row width register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
        end else if (i_cfg_we) begin
            r_row_width <= i_cfg_wdata;
        end
    end

    // Clamp the width to one..MAX_COLS and detect the last column of a row.
    always_comb begin
        width_ext = CMPW'(r_row_width);
        if (width_ext == '0) begin
            eff_width = ONE_CMP;
        end else if (width_ext > MAX_CMP) begin
            eff_width = MAX_CMP;
        end else begin
            eff_width = width_ext;
        end
        col_next = CMPW'(r_col) + ONE_CMP;
        row_wrap = (col_next >= eff_width);
    end

    // Column counter and first-row flag advance on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else if (i_acc) begin
            if (i_matrix_end) begin
                r_col   <= '0;
                r_first <= 1'b1;
            end else if (row_wrap) begin
                r_col   <= '0;
                r_first <= 1'b0;
            end else begin
                r_col <= col_next[ADDR_W-1:0];
            end
        end
    end

    // Stage one valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_acc;
        end
    end

    // Stage one payload, plus forwarding of a write to the column now being read.
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_cell  <= i_cell_bit;
            r_s1_last  <= i_matrix_end;
            r_s1_col   <= r_col;
            r_s1_col0  <= (r_col == '0);
            r_s1_first <= r_first;
            r_fwd      <= r_s1_vld && (r_s1_col == r_col);
            r_fwd_data <= side;
        end
    end

    // Side of the cell in stage one: zero for an empty cell, else one plus the smallest neighbor, saturated.
    always_comb begin
        prev_side = r_fwd ? r_fwd_data : i_rd_data;
        up        = r_s1_first ? SIDE_ZERO : prev_side;
        left      = r_s1_col0 ? SIDE_ZERO : r_left;
        diag      = (r_s1_col0 || r_s1_first) ? SIDE_ZERO : r_diag;
        min_lu    = (up < left) ? up : left;
        min3      = (min_lu < diag) ? min_lu : diag;
        sum       = {1'b0, min3} + {{SIDE_W{1'b0}}, 1'b1};
        if (!r_s1_cell) begin
            side = SIDE_ZERO;
        end else if (sum[SIDE_W]) begin
            side = SIDE_MAX;
        end else begin
            side = sum[SIDE_W-1:0];
        end
        best_new = (side > r_best) ? side : r_best;
    end

    // Neighbor and best-side state; the best side clears after the last cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= SIDE_ZERO;
            r_diag <= SIDE_ZERO;
            r_best <= SIDE_ZERO;
        end else if (r_s1_vld) begin
            r_left <= side;
            r_diag <= up;
            r_best <= r_s1_last ? SIDE_ZERO : best_new;
        end
    end

    // Line buffer: read at transfer, written back in the following cycle.
    assign o_rd_en   = i_acc;
    assign o_rd_addr = r_col;
    assign o_wr_en   = r_s1_vld;
    assign o_wr_addr = r_s1_col;
    assign o_wr_data = side;

    assign o_push.valid = r_s1_vld && r_s1_last;
    assign o_push.side  = best_new;

endmodule

[hw/rtl/msa_result.sv]
// Result stage: squares the best side and queues results for the output channel.
// Depends on msa_pkg and the assertion macros header.
`include "maximal_square_area_defines.svh"

module msa_result
    import msa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_acc_last,
    input  t_res_push i_push,
    output logic      o_in_ready,
    output logic      o_valid,
    input  logic      i_ready,
    output t_area     o_area,
    output t_side     o_side
);

    localparam int PW = $clog2(RES_DEPTH);
    localparam int CW = $clog2(RES_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(RES_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic          r_s2_vld;
    t_side         r_s2_side;
    t_area         r_area [RES_DEPTH];
    t_side         r_side [RES_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] r_pend;
    logic [CW-1:0] n_pend;
    logic          pop;
    logic [2*SIDE_W-1:0] square;

    assign pop    = o_valid && i_ready;
    assign square = {{SIDE_W{1'b0}}, r_s2_side} * {{SIDE_W{1'b0}}, r_s2_side};

    // Stage two holds the side of a finished matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= i_push.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_s2_side <= i_push.side;
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_area[r_wp] <= square[AREA_W-1:0];
            r_side[r_wp] <= r_s2_side;
        end
    end

    // Queue pointers, fill count and count of results owed downstream.
    always_comb begin
        n_cnt  = r_cnt;
        n_pend = r_pend;
        if (r_s2_vld) begin
            n_cnt = n_cnt + ONE_C;
        end
        if (pop) begin
            n_cnt  = n_cnt - ONE_C;
            n_pend = n_pend - ONE_C;
        end
        if (i_acc_last) begin
            n_pend = n_pend + ONE_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_pend <= '0;
        end else begin
            if (r_s2_vld) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
        end
    end

    // Input is taken while the queue can still absorb one more result.
    assign o_in_ready = (r_pend < DEPTH_C);
    assign o_valid    = (r_cnt != '0);
    assign o_area     = r_area[r_rp];
    assign o_side     = r_side[r_rp];

    `MSA_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, r_cnt == DEPTH_C, !r_s2_vld, "result queue overflow")
    `MSA_ASSERT_NOW(a_pend_covers, i_clk, i_rst_n, 1'b1, r_pend >= r_cnt, "queued results exceed owed results")
    `MSA_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, r_s2_vld, o_valid, "pushed result not visible")
    `MSA_ASSERT_NEXT(a_pend_bound, i_clk, i_rst_n, 1'b1, r_pend <= DEPTH_C, "owed result count out of range")

endmodule

[hw/rtl/maximal_square_area.sv]
// Top level of the maximal square area block: config register, cell pipeline,
// line buffer and result queue. Depends on msa_pkg, msa_if and the submodules.
//
//  Channel   Direction  Payload                      Handshake
//  i_cell    in         cell_bit, matrix_end         valid/ready
//  o_res     out        square_area, square_side     valid/ready
//  i_cfg     in         row_width (i_cfg_wdata)      write enable only
//
// One cell per cycle while input is not held off: the line buffer is read at transfer and written back the
// next cycle, with the previous cell's side forwarded when the columns match.
// A result passes through stage one, stage two and the result queue before it leaves.
// Synchronous active-low reset; no clearing pass, the buffer's read data is
// ignored in the first row of a matrix.
// Input is held off only while four results are owed downstream.
module maximal_square_area
    import msa_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_row_width i_cfg_wdata,
    msa_in_if.sink     i_cell,
    msa_out_if.source  o_res
);

    localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic              acc;
    logic              in_ready;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_side             rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_side             wr_data;
    t_res_push         push;

    // An input transfer.
    assign acc          = i_cell.valid && in_ready;
    assign i_cell.ready = in_ready;

    msa_cell #(
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_cell (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_acc        (acc),
        .i_cell_bit   (i_cell.cell_bit),
        .i_matrix_end (i_cell.matrix_end),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_push       (push)
    );

    msa_lbuf #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (ADDR_W)
    ) u_lbuf (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    msa_result u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc_last (acc && i_cell.matrix_end),
        .i_push     (push),
        .o_in_ready (in_ready),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_area     (o_res.square_area),
        .o_side     (o_res.square_side)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for maximal_square_area: streams binary matrices and checks
// each largest-square result against an in-bench prediction of the raster algorithm.
// Depends on msa_pkg, msa_if and the maximal_square_area RTL.
module testbench;
    import msa_pkg::*;

    localparam int LINE_COLS    = MAX_COLS_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 10;

    // One expected result per matrix.
    typedef struct {
        t_area area;
        t_side side;
    } t_square_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_row_width i_cfg_wdata;

    msa_in_if  cell_if ();
    msa_out_if res_if ();

    maximal_square_area #(
        .MAX_COLS(LINE_COLS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cell     (cell_if),
        .o_res      (res_if)
    );

    // Predicted state of the square search.
    t_side       line_sides [LINE_COLS];
    t_side       left_q;
    t_side       diag_q;
    t_side       best_q;
    int unsigned col_q;
    logic        first_row_q;
    int unsigned row_width_q;

    t_square_result pending_squares [$];

    int unsigned cycle_count    = 0;
    int unsigned error_count    = 0;
    int unsigned cells_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result checker; it also drives the random back-pressure on the result channel.
    always @(posedge i_clk) begin
        t_square_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (pending_squares.size() == 0) begin
                $error("unexpected result transfer: area %0d, side %0d",
                       res_if.square_area, res_if.square_side);
                error_count++;
            end else begin
                want = pending_squares.pop_front();
                if (res_if.square_area !== want.area) begin
                    $error("square_area mismatch: expected %0d, actual %0d",
                           want.area, res_if.square_area);
                    error_count++;
                end
                if (res_if.square_side !== want.side) begin
                    $error("square_side mismatch: expected %0d, actual %0d",
                           want.side, res_if.square_side);
                    error_count++;
                end
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Return the per-matrix state to its reset values; the line buffer is kept.
    function automatic void clear_square_state();
        left_q      = SIDE_ZERO;
        diag_q      = SIDE_ZERO;
        best_q      = SIDE_ZERO;
        col_q       = 0;
        first_row_q = 1'b1;
    endfunction

    // Advance the prediction by one transferred cell and queue a result on the matrix end.
    function automatic void advance_square_state(input logic cell_val, input logic last);
        int unsigned    width;
        int unsigned    col;
        int unsigned    best_sq;
        t_side          up;
        t_side          left;
        t_side          diag;
        t_side          least;
        t_side          side;
        t_square_result res;
        width = row_width_q;
        if (width < 1) width = 1;
        if (width > LINE_COLS) width = LINE_COLS;
        col = (col_q >= LINE_COLS) ? 0 : col_q;

        // Neighbors outside the matrix count as zero.
        up   = first_row_q ? SIDE_ZERO : line_sides[col];
        left = (col == 0) ? SIDE_ZERO : left_q;
        diag = (col == 0 || first_row_q) ? SIDE_ZERO : diag_q;

        least = (up < left) ? up : left;
        least = (least < diag) ? least : diag;
        if (!cell_val) begin
            side = SIDE_ZERO;
        end else if (least == SIDE_MAX) begin
            side = SIDE_MAX;
        end else begin
            side = least + 1'b1;
        end

        line_sides[col] = side;
        diag_q = up;
        left_q = side;
        if (side > best_q) best_q = side;

        // A new width takes effect at once, so the row can end early.
        if (col + 1 >= width) begin
            col_q       = 0;
            first_row_q = 1'b0;
        end else begin
            col_q = col + 1;
        end

        if (last) begin
            best_sq  = best_q;
            res.area = t_area'(best_sq * best_sq);
            res.side = best_q;
            pending_squares.push_back(res);
            clear_square_state();
        end
    endfunction

    // Send one cell, idling at random beforehand, and wait for its transfer.
    task automatic send_cell(input logic cell_val, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            cell_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.cell_bit   <= cell_val;
        cell_if.matrix_end <= last;
        @(posedge i_clk);
        while (!cell_if.ready) @(posedge i_clk);
        advance_square_state(cell_val, last);
        cells_sent++;
    endtask

    // Stop sending and wait until every result has come and the pipeline has settled.
    task automatic wait_drained();
        cell_if.valid <= 1'b0;
        while (pending_squares.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the row width register while the block is idle.
    task automatic set_row_width(input int unsigned value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t_row_width'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        row_width_q = value & 32'h7FF;
    endtask

    // Send cells 0..end_at of a rows x cols matrix, marking the cell at end_at as last.
    task automatic send_matrix(input int unsigned rows, input int unsigned cols,
                               input int unsigned fill_pct, input int unsigned end_at);
        int unsigned total;
        total = rows * cols;
        for (int unsigned k = 0; k < total && k <= end_at; k++) begin
            send_cell($urandom_range(99) < fill_pct, k == end_at);
        end
    endtask

    // Tiny matrices with known answers, including an end in the middle of a row.
    task automatic test_small_matrices();
        set_row_width(1);
        send_matrix(1, 1, 100, 0);
        send_matrix(1, 1, 0, 0);
        set_row_width(2);
        send_matrix(2, 2, 100, 3);
        set_row_width(3);
        send_matrix(3, 3, 100, 8);
        send_matrix(1, 3, 100, 1);
    endtask

    // Widths beyond both ends of the legal range and at its upper end; the wide rows stop early.
    task automatic test_width_limits();
        set_row_width(0);
        send_matrix(4, 1, 100, 3);
        set_row_width(2047);
        send_matrix(2, LINE_COLS, 100, 5);
        set_row_width(LINE_COLS + 1);
        send_matrix(2, LINE_COLS, 100, 5);
        set_row_width(LINE_COLS);
        send_matrix(2, LINE_COLS, 90, 5);
    endtask

    // Narrow the rows inside a matrix, once with the column count past the new width.
    task automatic test_width_change_mid_row();
        set_row_width(6);
        repeat (16) send_cell(1'b1, 1'b0);
        set_row_width(3);
        repeat (7) send_cell(1'b1, 1'b0);
        set_row_width(2);
        send_cell(1'b1, 1'b0);
        send_cell(1'b0, 1'b0);
        send_cell(1'b1, 1'b1);
    endtask

    // Random matrices under each idling pattern; some end early on purpose.
    task automatic test_random_traffic();
        int unsigned idle_pcts  [4] = '{0, 75, 0, 6};
        int unsigned stall_pcts [4] = '{0, 0, 75, 6};
        int unsigned cells_base;
        int unsigned results_base;
        int unsigned width;
        int unsigned cols;
        int unsigned width_uses;
        int unsigned rows;
        int unsigned total;
        int unsigned end_at;
        int unsigned fill_pct;
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            cells_base     = cells_sent;
            results_base   = results_seen;
            width_uses     = 0;
            cols           = 1;
            while (cells_sent - cells_base < 170 || results_seen - results_base < 8) begin
                // A fresh width every few matrices; mostly narrow rows.
                if (width_uses == 0) begin
                    case ($urandom_range(9))
                        0:       width = 0;
                        1:       width = $urandom_range(7, 40);
                        default: width = $urandom_range(1, 6);
                    endcase
                    set_row_width(width);
                    cols       = (width == 0) ? 1 : width;
                    width_uses = $urandom_range(1, 4);
                end
                width_uses--;
                case ($urandom_range(3))
                    0:       fill_pct = 40;
                    1:       fill_pct = 80;
                    2:       fill_pct = 95;
                    default: fill_pct = 100;
                endcase
                rows   = $urandom_range(1, 6);
                total  = rows * cols;
                end_at = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : total - 1;
                send_matrix(rows, cols, fill_pct, end_at);
            end
        end
    endtask

    // Main sequence: reset, then each test in turn, then the verdict.
    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= ROW_WIDTH_RST;
        cell_if.valid      <= 1'b0;
        cell_if.cell_bit   <= 1'b0;
        cell_if.matrix_end <= 1'b0;
        row_width_q         = ROW_WIDTH_RST;
        clear_square_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_matrices();
        test_width_limits();
        test_width_change_mid_row();
        test_random_traffic();
        wait_drained();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/msa_pkg.sv
hw/rtl/msa_if.sv
hw/rtl/msa_lbuf.sv
hw/rtl/msa_cell.sv
hw/rtl/msa_result.sv
hw/rtl/maximal_square_area.sv
tb/sv/testbench.sv
